// File: rtl/core/rre_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types, widths and codes of the rounded rectangle edge fade pipeline.
// ----------------------------------------------------------------------------
package rre_pkg;

  localparam int WINDOW_WIDTH_DEF  = 496;
  localparam int WINDOW_HEIGHT_DEF = 224;

  // geometry in signed Q8 pixels
  localparam int GW = 26;

  // outside offsets are clamped; anything this far out is already at full cover
  localparam int OFF_W = 18;
  localparam int SUM_W = 2 * OFF_W + 1;
  localparam int ROOT_IN_W = SUM_W + (SUM_W % 2);
  localparam int ROOT_W = ROOT_IN_W / 2;
  localparam int ROOT_STEPS = ROOT_W;
  localparam int ROOT_PER_STAGE = 2;
  localparam int ROOT_STAGES = (ROOT_STEPS + ROOT_PER_STAGE - 1) / ROOT_PER_STAGE;

  localparam int SPAN_W = 10;
  localparam int REM_W = SPAN_W + 1;
  localparam int Q_W = 16;
  localparam int DIV_PER_STAGE = 2;
  localparam int DIV_STAGES = Q_W / DIV_PER_STAGE;

  localparam int COVER_W = 17;
  localparam logic [COVER_W-1:0] COVER_FULL = 17'h10000;
  localparam logic [17:0] SMOOTH_THREE = 18'd196608;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REACH_LEFT    = 3'd0,
    CFG_REACH_RIGHT   = 3'd1,
    CFG_REACH_TOP     = 3'd2,
    CFG_REACH_BOTTOM  = 3'd3,
    CFG_FADE_SPAN     = 3'd4,
    CFG_CORNER_RADIUS = 3'd5,
    CFG_BOTTOM_LIFT   = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_FULL,
    KIND_RAMP
  } kind_t;

  typedef struct packed {
    logic valid;
    logic live;
  } ctl_t;

  typedef struct packed {
    logic  valid;
    kind_t kind;
  } tag_t;

  typedef struct packed {
    logic [8:0]        reach_left;
    logic [8:0]        reach_right;
    logic [8:0]        reach_top;
    logic [8:0]        reach_bottom;
    logic [SPAN_W-1:0] fade_span;
    logic [8:0]        corner_radius;
    logic [8:0]        bottom_lift;
  } cfg_t;

endpackage

// File: rtl/core/rounded_rect_edge_fade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_edge_fade
// Edge cover of a sprite anchor against a rounded, widened window.
//
//   channel  dir  handshake          payload
//   s_*      in   s_tvalid/s_tready  tdata: x, y, hw, made, cut; tuser: valid, world
//   m_*      out  m_tvalid/m_tready  tdata: cover_res (Q1.16)
//   cfg_*    in   cfg_valid/ready    cfg_index, cfg_data
//
// One record per cycle unless m_tready stalls. Stages: 5 geometry, 10 root
// (two root bits each, one in the last), 10 divide (distance, ramp class, then
// eight stages of two quotient bits each), 3 shaping.
// A stall on m_tready freezes every stage at once; s_tready follows it.
// rst clears the valid bits and loads the register reset values.
// cfg_ready is always high; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module rounded_rect_edge_fade #(
  parameter int WINDOW_WIDTH  = rre_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = rre_pkg::WINDOW_HEIGHT_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // point_x[15:0], point_y[31:16], hw_parts[39:32], made_parts[47:40], cut_parts[55:48]
  input  logic [55:0]                         s_tdata,
  // point_valid[0], world_tier[1]
  input  logic [1:0]                          s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // cover_res[16:0], zero fill [23:17]
  output logic [23:0]                         m_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rre_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [rre_pkg::CFG_DATA_W-1:0]      cfg_data
);

  rre_pkg::cfg_t cfg;
  logic en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.reach_left    <= '0;
      cfg.reach_right   <= '0;
      cfg.reach_top     <= '0;
      cfg.reach_bottom  <= '0;
      cfg.fade_span     <= rre_pkg::SPAN_W'(16);
      cfg.corner_radius <= '0;
      cfg.bottom_lift   <= '0;
    end else if (cfg_valid) begin
      unique case (rre_pkg::cfg_index_t'(cfg_index))
        rre_pkg::CFG_REACH_LEFT:    cfg.reach_left    <= cfg_data[8:0];
        rre_pkg::CFG_REACH_RIGHT:   cfg.reach_right   <= cfg_data[8:0];
        rre_pkg::CFG_REACH_TOP:     cfg.reach_top     <= cfg_data[8:0];
        rre_pkg::CFG_REACH_BOTTOM:  cfg.reach_bottom  <= cfg_data[8:0];
        rre_pkg::CFG_FADE_SPAN:     cfg.fade_span     <= cfg_data;
        rre_pkg::CFG_CORNER_RADIUS: cfg.corner_radius <= cfg_data[8:0];
        rre_pkg::CFG_BOTTOM_LIFT:   cfg.bottom_lift   <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign en = !m_tvalid || m_tready;
  assign s_tready = en;

  rre_pkg::ctl_t in_ctl, g_ctl, r_ctl;
  logic [rre_pkg::SUM_W-1:0] g_sum;
  logic signed [rre_pkg::GW-1:0] g_lneg, g_rad, r_lneg;
  logic [rre_pkg::ROOT_W-1:0] r_root;
  rre_pkg::tag_t d_tag;
  logic [rre_pkg::Q_W-1:0] d_quo;
  logic [rre_pkg::COVER_W-1:0] cover_val;

  // a record counts only when valid, world tier and with some parts
  assign in_ctl.valid = s_tvalid;
  assign in_ctl.live = s_tuser[0] && s_tuser[1] && (s_tdata[55:32] != '0);

  rre_geom #(
    .WINDOW_WIDTH (WINDOW_WIDTH),
    .WINDOW_HEIGHT(WINDOW_HEIGHT)
  ) u_geom (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_ctl (in_ctl),
    .px     ($signed(s_tdata[15:0])),
    .py     ($signed(s_tdata[31:16])),
    .cfg    (cfg),
    .out_ctl(g_ctl),
    .sum    (g_sum),
    .lneg   (g_lneg),
    .rad    (g_rad)
  );

  rre_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (g_ctl),
    .sum     (g_sum),
    .in_lneg (g_lneg),
    .out_ctl (r_ctl),
    .root    (r_root),
    .out_lneg(r_lneg)
  );

  rre_div u_div (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .in_ctl (r_ctl),
    .outside(r_root),
    .lneg   (r_lneg),
    .rad    (g_rad),
    .span   (cfg.fade_span),
    .out_tag(d_tag),
    .quo    (d_quo)
  );

  rre_shape u_shape (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_tag   (d_tag),
    .quo      (d_quo),
    .out_valid(m_tvalid),
    .cover_val(cover_val)
  );

  assign m_tdata = {7'b0, cover_val};

  a_cover_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[16:0] <= rre_pkg::COVER_FULL)
    else $error("cover above full scale");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(d_tag) && $stable(d_quo))
    else $error("divider moved during a stall");

endmodule

// File: rtl/core/rre_geom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_geom
// Window geometry, corner offsets and their squared sum (five stages).
// ----------------------------------------------------------------------------
module rre_geom #(
  parameter int WINDOW_WIDTH  = rre_pkg::WINDOW_WIDTH_DEF,
  parameter int WINDOW_HEIGHT = rre_pkg::WINDOW_HEIGHT_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  rre_pkg::ctl_t                     in_ctl,
  input  logic signed [15:0]                px,
  input  logic signed [15:0]                py,
  input  rre_pkg::cfg_t                     cfg,
  output rre_pkg::ctl_t                     out_ctl,
  output logic [rre_pkg::SUM_W-1:0]         sum,
  output logic signed [rre_pkg::GW-1:0]     lneg,
  output logic signed [rre_pkg::GW-1:0]     rad
);

  localparam int GW = rre_pkg::GW;
  localparam int OFF_W = rre_pkg::OFF_W;
  localparam logic [11:0] WX = 12'(WINDOW_WIDTH);
  localparam logic [11:0] HY = 12'(WINDOW_HEIGHT);
  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  // window constants, refreshed from the registers every cycle
  logic [11:0] tx, ty;
  logic signed [GW-1:0] hx, hy, cx, cy, lim, lift_q8, ins, shorter, rad_cap, rad_c;
  logic signed [GW-1:0] gc_cx, gc_cy, gc_hxr, gc_hyr, gc_rad;

  always_comb begin
    tx = WX + 12'(cfg.reach_right) + 12'(cfg.reach_left);
    ty = HY + 12'(cfg.reach_bottom) + 12'(cfg.reach_top);
    hx = $signed(GW'(tx)) <<< 7;
    cx = ($signed(GW'(WX)) + $signed(GW'(cfg.reach_right))
          - $signed(GW'(cfg.reach_left))) <<< 7;
    lim = $signed(GW'(ty)) <<< 7;
    lift_q8 = $signed(GW'(cfg.bottom_lift)) <<< 8;
    ins = (lift_q8 > lim) ? lim : lift_q8;
    hy = (($signed(GW'(ty)) <<< 8) - ins) >>> 1;
    cy = ((($signed(GW'(HY)) + $signed(GW'(cfg.reach_bottom))
           - $signed(GW'(cfg.reach_top))) <<< 8) - ins) >>> 1;
    shorter = (hx < hy) ? hx : hy;
    rad_cap = $signed(GW'(cfg.corner_radius)) <<< 8;
    rad_c = (rad_cap > shorter) ? shorter : rad_cap;
  end

  always_ff @(posedge clk) begin
    gc_cx  <= cx;
    gc_cy  <= cy;
    gc_hxr <= hx - rad_c;
    gc_hyr <= hy - rad_c;
    gc_rad <= rad_c;
  end

  assign rad = gc_rad;

  rre_pkg::ctl_t c1, c2, c3, c4, c5;
  logic signed [GW-1:0] p1x, p1y, q2x, q2y, lneg3, lneg4, lneg5;
  logic signed [GW-1:0] dx, dy, ax, ay, lm;
  logic [OFF_W-1:0] o3x, o3y, ox, oy;
  logic [2*OFF_W-1:0] s4x, s4y;
  logic [rre_pkg::SUM_W-1:0] sum5;

  always_ff @(posedge clk) begin
    if (rst) begin
      c1 <= '0;
      c2 <= '0;
      c3 <= '0;
      c4 <= '0;
      c5 <= '0;
    end else if (en) begin
      c1 <= in_ctl;
      c2 <= c1;
      c3 <= c2;
      c4 <= c3;
      c5 <= c4;
    end
  end

  always_comb begin
    dx = p1x - gc_cx;
    dy = p1y - gc_cy;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    ox = (q2x <= 0) ? '0 : (q2x > $signed(GW'(OFF_MAX))) ? OFF_MAX : q2x[OFF_W-1:0];
    oy = (q2y <= 0) ? '0 : (q2y > $signed(GW'(OFF_MAX))) ? OFF_MAX : q2y[OFF_W-1:0];
    lm = (q2x > q2y) ? q2x : q2y;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1x   <= $signed({{(GW-24){px[15]}}, px, 8'b0});
      p1y   <= $signed({{(GW-24){py[15]}}, py, 8'b0});
      q2x   <= ax - gc_hxr;
      q2y   <= ay - gc_hyr;
      o3x   <= ox;
      o3y   <= oy;
      lneg3 <= (lm < 0) ? lm : '0;
      s4x   <= o3x * o3x;
      s4y   <= o3y * o3y;
      lneg4 <= lneg3;
      sum5  <= rre_pkg::SUM_W'(s4x) + rre_pkg::SUM_W'(s4y);
      lneg5 <= lneg4;
    end
  end

  assign out_ctl = c5;
  assign sum = sum5;
  assign lneg = lneg5;

endmodule

// File: rtl/core/rre_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_sqrt
// Pipelined bit-serial integer square root, up to two result bits per stage.
// ----------------------------------------------------------------------------
module rre_sqrt (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  rre_pkg::ctl_t                     in_ctl,
  input  logic [rre_pkg::SUM_W-1:0]         sum,
  input  logic signed [rre_pkg::GW-1:0]     in_lneg,
  output rre_pkg::ctl_t                     out_ctl,
  output logic [rre_pkg::ROOT_W-1:0]        root,
  output logic signed [rre_pkg::GW-1:0]     out_lneg
);

  localparam int RIW = rre_pkg::ROOT_IN_W;
  localparam int NS = rre_pkg::ROOT_STAGES;
  localparam int PER = rre_pkg::ROOT_PER_STAGE;
  localparam int STEPS = rre_pkg::ROOT_STEPS;

  logic [RIW-1:0] v_q [NS];
  logic [RIW-1:0] r_q [NS];
  logic signed [rre_pkg::GW-1:0] lneg_q [NS];
  rre_pkg::ctl_t ctl_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RIW-1:0] v_in, r_in, v_nx, r_nx;
    logic signed [rre_pkg::GW-1:0] lneg_in;
    rre_pkg::ctl_t ctl_in;

    if (s == 0) begin : g_first
      assign v_in = RIW'(sum);
      assign r_in = '0;
      assign lneg_in = in_lneg;
      assign ctl_in = in_ctl;
    end else begin : g_next
      assign v_in = v_q[s-1];
      assign r_in = r_q[s-1];
      assign lneg_in = lneg_q[s-1];
      assign ctl_in = ctl_q[s-1];
    end

    always_comb begin
      logic [RIW-1:0] bitv;
      v_nx = v_in;
      r_nx = r_in;
      bitv = '0;
      for (int k = 0; k < PER; k++) begin
        if (s * PER + k < STEPS) begin
          bitv = RIW'(1) << (RIW - 2 - 2 * (s * PER + k));
          if (v_nx >= r_nx + bitv) begin
            v_nx = v_nx - (r_nx + bitv);
            r_nx = (r_nx >> 1) + bitv;
          end else begin
            r_nx = r_nx >> 1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[s] <= '0;
      end else if (en) begin
        ctl_q[s] <= ctl_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        v_q[s]    <= v_nx;
        r_q[s]    <= r_nx;
        lneg_q[s] <= lneg_in;
      end
    end
  end

  assign out_ctl = ctl_q[NS-1];
  assign root = r_q[NS-1][rre_pkg::ROOT_W-1:0];
  assign out_lneg = lneg_q[NS-1];

endmodule

// File: rtl/core/rre_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_div
// Signed distance, ramp classification and pipelined restoring divide by span.
// ----------------------------------------------------------------------------
module rre_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  rre_pkg::ctl_t                       in_ctl,
  input  logic [rre_pkg::ROOT_W-1:0]          outside,
  input  logic signed [rre_pkg::GW-1:0]       lneg,
  input  logic signed [rre_pkg::GW-1:0]       rad,
  input  logic [rre_pkg::SPAN_W-1:0]          span,
  output rre_pkg::tag_t                       out_tag,
  output logic [rre_pkg::Q_W-1:0]             quo
);

  localparam int GW = rre_pkg::GW;
  localparam int SW = rre_pkg::SPAN_W;
  localparam int RW = rre_pkg::REM_W;
  localparam int QW = rre_pkg::Q_W;
  localparam int NS = rre_pkg::DIV_STAGES;
  localparam int PER = rre_pkg::DIV_PER_STAGE;

  logic [SW-1:0] spn;
  logic signed [GW-1:0] spq, sdist, num0, num_q;
  rre_pkg::ctl_t c0;
  rre_pkg::tag_t t1;
  rre_pkg::kind_t kind1;
  logic [RW-1:0] rem1;
  logic [QW-1:0] low1;

  // zero span acts as one
  always_comb begin
    spn = (span == '0) ? SW'(1) : span;
    spq = $signed(GW'(spn)) <<< 8;
    sdist = $signed(GW'(outside)) + lneg - rad;
    num0 = sdist + spq;
    if (!c0.live || num_q <= 0) begin
      kind1 = rre_pkg::KIND_ZERO;
    end else if (num_q >= spq) begin
      kind1 = rre_pkg::KIND_FULL;
    end else begin
      kind1 = rre_pkg::KIND_RAMP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c0 <= '0;
      t1 <= '0;
    end else if (en) begin
      c0 <= in_ctl;
      t1 <= '{valid: c0.valid, kind: kind1};
    end
  end

  // dividend is num * 256; its top part already sits below the divisor
  always_ff @(posedge clk) begin
    if (en) begin
      num_q <= num0;
      rem1  <= {1'b0, num_q[8 +: SW]};
      low1  <= {num_q[7:0], 8'b0};
    end
  end

  logic [RW-1:0] rem_q [NS];
  logic [QW-1:0] low_q [NS];
  logic [QW-1:0] quo_q [NS];
  rre_pkg::tag_t tag_q [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic [RW-1:0] rem_in, rem_nx;
    logic [QW-1:0] low_in, low_nx, quo_in, quo_nx;
    rre_pkg::tag_t tag_in;

    if (s == 0) begin : g_first
      assign rem_in = rem1;
      assign low_in = low1;
      assign quo_in = '0;
      assign tag_in = t1;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign low_in = low_q[s-1];
      assign quo_in = quo_q[s-1];
      assign tag_in = tag_q[s-1];
    end

    always_comb begin
      rem_nx = rem_in;
      low_nx = low_in;
      quo_nx = quo_in;
      for (int k = 0; k < PER; k++) begin
        rem_nx = {rem_nx[RW-2:0], low_nx[QW-1]};
        low_nx = {low_nx[QW-2:0], 1'b0};
        if (rem_nx >= RW'(spn)) begin
          rem_nx = rem_nx - RW'(spn);
          quo_nx = {quo_nx[QW-2:0], 1'b1};
        end else begin
          quo_nx = {quo_nx[QW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        tag_q[s] <= '0;
      end else if (en) begin
        tag_q[s] <= tag_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= rem_nx;
        low_q[s] <= low_nx;
        quo_q[s] <= quo_nx;
      end
    end
  end

  assign out_tag = tag_q[NS-1];
  assign quo = quo_q[NS-1];

endmodule

// File: rtl/core/rre_shape.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rre_shape
// Smoothstep r*r*(3-2r) on the Q0.16 ramp and the output register.
// ----------------------------------------------------------------------------
module rre_shape (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              en,
  input  rre_pkg::tag_t                     in_tag,
  input  logic [rre_pkg::Q_W-1:0]           quo,
  output logic                              out_valid,
  output logic [rre_pkg::COVER_W-1:0]       cover_val
);

  localparam int QW = rre_pkg::Q_W;

  rre_pkg::tag_t t1, t2;
  logic [2*QW-1:0] sq1;
  logic [QW+1:0] tw1;
  logic [3*QW+1:0] prod2;
  logic [rre_pkg::COVER_W-1:0] cover_nx;

  always_comb begin
    case (t2.kind)
      rre_pkg::KIND_FULL: cover_nx = rre_pkg::COVER_FULL;
      rre_pkg::KIND_RAMP: cover_nx = prod2[2*QW +: rre_pkg::COVER_W];
      default:            cover_nx = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      t1 <= in_tag;
      t2 <= t1;
      out_valid <= t2.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq1       <= quo * quo;
      tw1       <= rre_pkg::SMOOTH_THREE - {1'b0, quo, 1'b0};
      prod2     <= sq1 * tw1;
      cover_val <= cover_nx;
    end
  end

endmodule

// File: test/rounded_rect_edge_fade_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rounded_rect_edge_fade_tb
// Streams sprite records through the edge fade block under several window
// settings and checks every cover value against a predictor kept in the bench.
// The sender runs in random bursts and the receiver stalls on its own pattern,
// with long hold-offs that back the pipeline up to its input.
// ----------------------------------------------------------------------------
module rounded_rect_edge_fade_tb;

  localparam logic [rre_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               valid;
    logic               world;
    logic [7:0]         hw;
    logic [7:0]         made;
    logic [7:0]         cut;
  } record_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rre_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [rre_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  rounded_rect_edge_fade u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  rre_pkg::cfg_t window_cfg;
  record_t record_q[$];
  record_t record_cur;
  logic [16:0] cover_q[$];
  int records_sent = 0;
  int covers_seen = 0;
  int cfg_writes = 0;
  int mismatches = 0;
  int burst_left = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int cycle_cnt = 0;
  int hold_left = 0;
  int stall_mode = 0;

  function automatic longint abs_l(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, t;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      t = res | (64'd1 << b);
      if (t * t <= v) res = t;
    end
    return res;
  endfunction

  function automatic logic [16:0] cover_predict(record_t rec, rre_pkg::cfg_t c);
    longint x0, x1, y0, y1, hx, hy, cx, cy, rad, shorter, qx, qy, ox, oy;
    longint longest, sdist, span, num, lim, ins;
    longint unsigned outside, r;
    if (!(rec.valid && rec.world && (rec.hw | rec.made | rec.cut) != 0)) return '0;
    x0 = -longint'(c.reach_left) * 256;
    x1 = (longint'(rre_pkg::WINDOW_WIDTH_DEF) + longint'(c.reach_right)) * 256;
    y0 = -longint'(c.reach_top) * 256;
    y1 = (longint'(rre_pkg::WINDOW_HEIGHT_DEF) + longint'(c.reach_bottom)) * 256;
    if (c.bottom_lift != 0) begin
      lim = (y1 - y0) / 2;
      ins = longint'(c.bottom_lift) * 256;
      if (ins > lim) ins = lim;
      y1 -= ins;
    end
    hx = (x1 - x0) / 2;
    hy = (y1 - y0) / 2;
    cx = (x0 + x1) / 2;
    cy = (y0 + y1) / 2;
    rad = longint'(c.corner_radius) * 256;
    shorter = hx < hy ? hx : hy;
    if (rad > shorter) rad = shorter;
    if (rad < 0) rad = 0;
    qx = abs_l(longint'(rec.x) * 256 - cx) - (hx - rad);
    qy = abs_l(longint'(rec.y) * 256 - cy) - (hy - rad);
    ox = qx > 0 ? qx : 0;
    oy = qy > 0 ? qy : 0;
    outside = int_root(longint'(ox * ox) + longint'(oy * oy));
    longest = qx > qy ? qx : qy;
    sdist = longint'(outside) + (longest < 0 ? longest : 0) - rad;
    if (sdist > 2048 * 256 - 1) sdist = 2048 * 256 - 1;
    if (sdist < -2048 * 256) sdist = -2048 * 256;
    span = c.fade_span == 0 ? 1 : longint'(c.fade_span);
    num = sdist + span * 256;
    if (num <= 0) return '0;
    if (num >= span * 256) return rre_pkg::COVER_FULL;
    r = (num * 256) / span;
    return 17'((r * r * (64'd196608 - 2 * r)) >> 32);
  endfunction

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = s_tvalid;
    if (rst) begin
      nxt_valid = 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        cover_q.push_back(cover_predict(record_cur, window_cfg));
        records_sent++;
      end
      if (!s_tvalid || s_tready) begin
        nxt_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (record_q.size() > 0) begin
          record_cur = record_q.pop_front();
          s_tdata <= {record_cur.cut, record_cur.made, record_cur.hw,
                      record_cur.y, record_cur.x};
          s_tuser <= {record_cur.world, record_cur.valid};
          nxt_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    s_tvalid <= nxt_valid;
  end

  // receiver: stall pattern is redrawn at random from four modes, plus long hold-offs
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b1;
    end else begin
      cycle_cnt++;
      if (cycle_cnt % 64 == 0) stall_mode = $urandom_range(0, 3);
      if (cycle_cnt == 1500 || cycle_cnt == 12000) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 9) < 7);
          2: m_tready <= (cycle_cnt % 3 == 0);
          default: m_tready <= ($urandom_range(0, 1) == 1);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    logic [16:0] want;
    if (!rst && m_tvalid && m_tready) begin
      covers_seen++;
      if (cover_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected cover transfer: %h", m_tdata);
      end else begin
        want = cover_q.pop_front();
        if (m_tdata !== {7'd0, want}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("cover mismatch: expected %h actual %h", {7'd0, want}, m_tdata);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d covers outstanding", cover_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [rre_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [9:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      rre_pkg::CFG_REACH_LEFT:    window_cfg.reach_left = data[8:0];
      rre_pkg::CFG_REACH_RIGHT:   window_cfg.reach_right = data[8:0];
      rre_pkg::CFG_REACH_TOP:     window_cfg.reach_top = data[8:0];
      rre_pkg::CFG_REACH_BOTTOM:  window_cfg.reach_bottom = data[8:0];
      rre_pkg::CFG_FADE_SPAN:     window_cfg.fade_span = data;
      rre_pkg::CFG_CORNER_RADIUS: window_cfg.corner_radius = data[8:0];
      rre_pkg::CFG_BOTTOM_LIFT:   window_cfg.bottom_lift = data[8:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input int l, r, t, b, span, rad, lift);
    write_reg(rre_pkg::CFG_REACH_LEFT, 10'(l));
    write_reg(rre_pkg::CFG_REACH_RIGHT, 10'(r));
    write_reg(rre_pkg::CFG_REACH_TOP, 10'(t));
    write_reg(rre_pkg::CFG_REACH_BOTTOM, 10'(b));
    write_reg(rre_pkg::CFG_FADE_SPAN, 10'(span));
    write_reg(rre_pkg::CFG_CORNER_RADIUS, 10'(rad));
    write_reg(rre_pkg::CFG_BOTTOM_LIFT, 10'(lift));
  endtask

  task automatic wait_drained();
    while (record_q.size() > 0 || s_tvalid || cover_q.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_record(input int x, y, input bit v, w, input int hw, made, cut);
    record_t rec;
    rec.x = 16'(x);
    rec.y = 16'(y);
    rec.valid = v;
    rec.world = w;
    rec.hw = 8'(hw);
    rec.made = 8'(made);
    rec.cut = 8'(cut);
    record_q.push_back(rec);
  endtask

  task automatic add_random(input int n);
    record_t rec;
    int pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        // live record anchored in or around the window
        rec.x = 16'($urandom_range(0, 1800) - 650);
        rec.y = 16'($urandom_range(0, 1400) - 600);
        rec.valid = 1'b1;
        rec.world = 1'b1;
        rec.hw = $urandom_range(0, 2) == 0 ? 8'd0 : 8'($urandom);
        rec.made = $urandom_range(0, 2) == 0 ? 8'd0 : 8'($urandom);
        rec.cut = 8'($urandom);
        if ((rec.hw | rec.made | rec.cut) == 0) rec.cut = 8'd1;
      end else begin
        rec.x = 16'($urandom);
        rec.y = 16'($urandom);
        rec.valid = 1'($urandom);
        rec.world = 1'($urandom);
        rec.hw = 8'($urandom);
        rec.made = 8'($urandom);
        rec.cut = 8'($urandom);
        if (pick < 85) {rec.hw, rec.made, rec.cut} = '0;
      end
      record_q.push_back(rec);
    end
  endtask

  initial begin
    window_cfg = '{reach_left: 9'd0, reach_right: 9'd0, reach_top: 9'd0,
                   reach_bottom: 9'd0, fade_span: 10'd16, corner_radius: 9'd0,
                   bottom_lift: 9'd0};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed records at reset settings
    add_record(248, 112, 1, 1, 1, 0, 0);
    add_record(0, 0, 1, 1, 0, 1, 0);
    add_record(496, 224, 1, 1, 0, 0, 1);
    add_record(-8, 112, 1, 1, 255, 255, 255);
    add_record(504, 112, 1, 1, 3, 0, 0);
    add_record(248, -16, 1, 1, 3, 0, 0);
    add_record(248, 240, 1, 1, 3, 0, 0);
    add_record(-5, -5, 1, 1, 3, 0, 0);
    add_record(-32768, -32768, 1, 1, 1, 1, 1);
    add_record(32767, 32767, 1, 1, 1, 1, 1);
    add_record(-32768, 32767, 1, 1, 128, 0, 0);
    add_record(248, 112, 0, 1, 1, 1, 1);
    add_record(248, 112, 1, 0, 1, 1, 1);
    add_record(248, 112, 1, 1, 0, 0, 0);
    add_record(-32768, -32768, 0, 0, 0, 0, 0);
    add_record(-1, -1, 0, 0, 255, 255, 255);
    add_record(-12, 112, 1, 1, 9, 0, 0);
    add_random(150);
    wait_drained();

    // zero span acts as one, everything else at its low end
    set_window(0, 0, 0, 0, 0, 0, 0);
    add_record(-1, 100, 1, 1, 1, 0, 0);
    add_record(496, 100, 1, 1, 1, 0, 0);
    add_random(150);
    wait_drained();

    // every register at its top, radius past its cap
    set_window(511, 511, 511, 511, 1023, 511, 511);
    add_record(1007, 734, 1, 1, 1, 0, 0);
    add_record(-1534, -1534, 1, 1, 1, 0, 0);
    add_random(150);
    wait_drained();

    // tenth data bit must be dropped on the narrow registers; unknown index ignored
    set_window(10'h208, 10'h210, 10'h204, 10'h220, 64, 10'h230, 10'h240);
    write_reg(CFG_UNUSED_INDEX, 10'h3FF);
    add_random(150);
    wait_drained();

    // lift past half height, corners fully rounded
    set_window(20, 40, 10, 0, 32, 300, 400);
    add_random(150);
    wait_drained();

    for (int p = 0; p < 3; p++) begin
      set_window($urandom_range(0, 511), $urandom_range(0, 511), $urandom_range(0, 511),
                 $urandom_range(0, 511), $urandom_range(0, 1023), $urandom_range(0, 511),
                 $urandom_range(0, 511));
      add_random(120);
      wait_drained();
    end

    mismatches += cover_q.size();
    $display("sent %0d records over %0d register writes, checked %0d covers",
             records_sent, cfg_writes, covers_seen);
    $display("settings spanned zero and full reaches, spans, radii and lifts");
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/rre_pkg.sv
rtl/core/rre_geom.sv
rtl/core/rre_sqrt.sv
rtl/core/rre_div.sv
rtl/core/rre_shape.sv
rtl/core/rounded_rect_edge_fade.sv
test/rounded_rect_edge_fade_tb.sv
